>>> design/grle_pkg.sv
`default_nettype none

package grle_pkg;

	// Result queue depth; one item may push two results in a cycle.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Field widths fixed by the interface.
	localparam int COORD_W = 12;
	localparam int LEN_W   = 13;
	localparam int VAL_W   = 32;

	// Reset value of the grid width register.
	localparam logic [LEN_W-1:0] GRID_WIDTH_RESET = 13'd64;

	// One emitted run.
	typedef struct packed {
		logic [COORD_W-1:0]      column;
		logic [COORD_W-1:0]      row;
		logic signed [VAL_W-1:0] value;
		logic [LEN_W-1:0]        length;
		logic                    last;
	} run_t;

endpackage

`default_nettype wire

>>> design/grid_row_run_length_encoder_unit.sv
`default_nettype none
// A cell transfer registers into the input stage, which writes its runs into a four-entry
// result queue once the queue has room; the head of the queue is the offered run.
// Throughput: one cell per cycle while the queue holds two free entries; an item that
// closes two runs pushes both at once, and runs drain one per cycle while out_ready is high.
// Reset: arst_n clears counters, the open run, the input stage and the queue at once;
// grid_width returns to 64.
module grid_row_run_length_encoder_unit #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [12:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] cell_value,
	input  logic               first_cell,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [11:0]        run_column,
	output logic [11:0]        run_row,
	output logic signed [31:0] run_value,
	output logic [12:0]        run_length,
	output logic               last_result
);
	import grle_pkg::*;

	localparam logic [16:0] MAX_W17 = 17'(MAX_WIDTH);
	localparam logic [16:0] MAX_H17 = 17'(MAX_HEIGHT);

	// Configuration register.
	logic [LEN_W-1:0] grid_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= GRID_WIDTH_RESET;
		end else if (cfg_wr_en) begin
			grid_width_q <= cfg_wr_data;
		end
	end

	// Input stage.
	logic                    valid_s1;
	logic signed [VAL_W-1:0] value_s1;
	logic                    first_s1;
	logic                    adv_s1;
	logic [CNT_W-1:0]        fifo_cnt_q;

	assign adv_s1   = valid_s1 && (fifo_cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			value_s1 <= cell_value;
			first_s1 <= first_cell;
		end
	end

	// Encoder state.
	logic [COORD_W-1:0]      col_q;
	logic [COORD_W-1:0]      row_q;
	logic [COORD_W-1:0]      open_start_q;
	logic signed [VAL_W-1:0] open_value_q;
	logic [LEN_W-1:0]        open_len_q;
	logic                    open_valid_q;

	// Clamp the configured width to the range 1 .. MAX_WIDTH.
	logic [16:0] gw17;
	logic [16:0] w_eff;

	always_comb begin
		gw17 = {4'b0, grid_width_q};
		if (gw17 == 17'd0) begin
			w_eff = 17'd1;
		end else if (gw17 > MAX_W17) begin
			w_eff = MAX_W17;
		end else begin
			w_eff = gw17;
		end
	end

	// Next state and the runs closed by the cell in the input stage.
	logic [COORD_W-1:0]      col0;
	logic [COORD_W-1:0]      row0;
	logic                    ov0;
	logic                    match;
	logic                    emit_a;
	logic                    emit_b;
	logic                    row_end;
	logic [COORD_W-1:0]      new_start;
	logic signed [VAL_W-1:0] new_value;
	logic [LEN_W-1:0]        new_len;
	logic [COORD_W-1:0]      row_wrap;
	logic [COORD_W-1:0]      row_next;
	run_t                    run_a;
	run_t                    run_b;

	always_comb begin
		col0  = first_s1 ? '0 : col_q;
		row0  = first_s1 ? '0 : row_q;
		ov0   = first_s1 ? 1'b0 : open_valid_q;
		match = ov0 && (open_value_q == value_s1);

		// A value change closes the open run, kept only when nonzero.
		emit_a = !match && ov0 && (open_value_q != '0);
		if (match) begin
			new_start = open_start_q;
			new_value = open_value_q;
			new_len   = open_len_q + LEN_W'(1);
		end else begin
			new_start = col0;
			new_value = value_s1;
			new_len   = LEN_W'(1);
		end

		// The row end closes the run that includes this cell.
		row_end = {5'b0, col0} >= (w_eff - 17'd1);
		emit_b  = row_end && (new_value != '0);

		row_wrap = row0 + COORD_W'(1);
		row_next = ({5'b0, row_wrap} >= MAX_H17) ? '0 : row_wrap;

		run_a.column = open_start_q;
		run_a.row    = row0;
		run_a.value  = open_value_q;
		run_a.length = open_len_q;
		run_a.last   = !emit_b;

		run_b.column = new_start;
		run_b.row    = row0;
		run_b.value  = new_value;
		run_b.length = new_len;
		run_b.last   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			open_start_q <= '0;
			open_value_q <= '0;
			open_len_q   <= '0;
			open_valid_q <= 1'b0;
		end else if (adv_s1) begin
			open_start_q <= new_start;
			open_value_q <= new_value;
			if (row_end) begin
				col_q        <= '0;
				row_q        <= row_next;
				open_len_q   <= '0;
				open_valid_q <= 1'b0;
			end else begin
				col_q        <= col0 + COORD_W'(1);
				row_q        <= row0;
				open_len_q   <= new_len;
				open_valid_q <= 1'b1;
			end
		end
	end

	// Result queue: up to two writes and one read per cycle.
	run_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [1:0]       n_push;
	logic             pop;
	run_t             head;

	assign n_push = adv_s1 ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
	assign head   = fifo_q[rd_ptr_q];
	assign pop    = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= emit_a ? run_a : run_b;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= run_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			wr_ptr_q   <= wr_ptr_q + PTR_W'(n_push);
			rd_ptr_q   <= rd_ptr_q + PTR_W'(pop);
			fifo_cnt_q <= fifo_cnt_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

	// Output side.
	assign out_valid   = (fifo_cnt_q != '0);
	assign run_column  = head.column;
	assign run_row     = head.row;
	assign run_value   = head.value;
	assign run_length  = head.length;
	assign last_result = head.last;

	// The queue never overfills.
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	// Zero-valued runs are never emitted.
	a_no_zero_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (run_value != '0))
		else $error("zero-valued run emitted");

	// Emitted runs always have a nonzero length.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (run_length != '0))
		else $error("run of zero length emitted");

	// A row end closes the open run and returns the column to zero.
	a_row_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && row_end) |=> !open_valid_q && (col_q == '0))
		else $error("run left open across a row end");

endmodule

`default_nettype wire

>>> sim/grid_row_run_length_encoder_unit_tb.sv
`default_nettype none

module grid_row_run_length_encoder_unit_tb;
	import grle_pkg::*;

	localparam int CELLS_MAX = 4096;
	localparam int ROWS_MAX  = 4096;

	// Tracks the row position and the open run, and keeps the runs still owed by the block.
	class run_tracker;
		logic [LEN_W-1:0]        width_reg = GRID_WIDTH_RESET;
		logic [COORD_W-1:0]      col       = '0;
		logic [COORD_W-1:0]      row       = '0;
		logic [COORD_W-1:0]      run_col   = '0;
		logic signed [VAL_W-1:0] run_val   = '0;
		logic [LEN_W-1:0]        run_len   = '0;
		logic                    run_open  = 1'b0;
		run_t                    runs_due[$];
		int                      failures  = 0;

		// A closed run is owed only when it holds a nonzero value.
		function void close_run();
			run_t r;
			if (!run_open || run_val == 0)
				return;
			r.column = run_col;
			r.row    = row;
			r.value  = run_val;
			r.length = run_len;
			r.last   = 1'b0;
			runs_due.push_back(r);
		endfunction

		// Advances the position by one accepted cell and queues the runs it closes.
		function void take_cell(logic signed [VAL_W-1:0] v, logic f);
			int   span;
			int   owed;
			run_t r;
			span = int'(width_reg);
			if (span == 0)
				span = 1;
			if (span > CELLS_MAX)
				span = CELLS_MAX;
			owed = runs_due.size();
			if (f) begin
				col      = '0;
				row      = '0;
				run_open = 1'b0;
			end
			if (run_open && run_val == v) begin
				run_len = run_len + LEN_W'(1);
			end else begin
				close_run();
				run_open = 1'b1;
				run_val  = v;
				run_col  = col;
				run_len  = LEN_W'(1);
			end
			// The row ends here, also when the width was lowered below the column.
			if (int'(col) >= span - 1) begin
				close_run();
				run_open = 1'b0;
				run_len  = '0;
				col      = '0;
				row      = row + COORD_W'(1);
				if (int'(row) >= ROWS_MAX)
					row = '0;
			end else begin
				col = col + COORD_W'(1);
			end
			if (runs_due.size() > owed) begin
				r = runs_due.pop_back();
				r.last = 1'b1;
				runs_due.push_back(r);
			end
		endfunction

		// Compares one run transfer with the oldest owed run.
		function void match_run(logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
				logic signed [VAL_W-1:0] v, logic [LEN_W-1:0] l, logic lst);
			run_t want;
			if (runs_due.size() == 0) begin
				$error("unexpected run: column %0d row %0d value %0d length %0d",
					c, r, v, l);
				failures++;
				return;
			end
			want = runs_due.pop_front();
			if (c !== want.column) begin
				$error("run_column: expected %0d, got %0d", want.column, c);
				failures++;
			end
			if (r !== want.row) begin
				$error("run_row: expected %0d, got %0d", want.row, r);
				failures++;
			end
			if (v !== want.value) begin
				$error("run_value: expected %0d, got %0d", want.value, v);
				failures++;
			end
			if (l !== want.length) begin
				$error("run_length: expected %0d, got %0d", want.length, l);
				failures++;
			end
			if (lst !== want.last) begin
				$error("last_result: expected %0d, got %0d", want.last, lst);
				failures++;
			end
		endfunction

		// Runs still owed at the end are failures.
		function void flag_missing();
			foreach (runs_due[i]) begin
				$error("missing run: column %0d row %0d value %0d length %0d",
					runs_due[i].column, runs_due[i].row, runs_due[i].value,
					runs_due[i].length);
				failures++;
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [LEN_W-1:0]        cfg_wr_data;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [VAL_W-1:0] cell_value;
	logic                    first_cell;
	logic                    out_valid;
	logic                    out_ready;
	logic [COORD_W-1:0]      run_column;
	logic [COORD_W-1:0]      run_row;
	logic signed [VAL_W-1:0] run_value;
	logic [LEN_W-1:0]        run_length;
	logic                    last_result;

	run_tracker              tracker = new;
	int                      gap_pct;
	int                      stall_pct;
	int                      stall_left;

	grid_row_run_length_encoder_unit #(
		.MAX_WIDTH (CELLS_MAX),
		.MAX_HEIGHT(ROWS_MAX)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cell_value (cell_value),
		.first_cell (first_cell),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.run_column (run_column),
		.run_row    (run_row),
		.run_value  (run_value),
		.run_length (run_length),
		.last_result(last_result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The receiver stalls in random bursts while stall_pct is nonzero.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 13);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Every run transfer is checked at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.match_run(run_column, run_row, run_value, run_length, last_result);
	end

	// Offers one cell, possibly after a gap, and holds it until the transfer.
	task automatic send_cell(input logic signed [VAL_W-1:0] v, input logic f);
		int gap;
		if ($urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		cell_value <= v;
		first_cell <= f;
		do @(posedge clk); while (!in_ready);
		tracker.take_cell(v, f);
		@(negedge clk);
	endtask

	// Stops offering cells and waits until every owed run has come out.
	task automatic settle();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (tracker.runs_due.size() > 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic set_width(input logic [LEN_W-1:0] w);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= w;
		tracker.width_reg = w;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Sends runs of repeated values drawn from a small palette that changes now and then.
	task automatic run_cells(input int n, input int restart_odds);
		logic signed [VAL_W-1:0] shades [4];
		logic signed [VAL_W-1:0] v;
		int                      sent;
		int                      len;
		logic                    f;
		sent = 0;
		shades[0] = '0;
		shades[1] = $signed($urandom);
		shades[2] = $signed($urandom);
		shades[3] = -1;
		while (sent < n) begin
			if ($urandom_range(0, 11) == 0) begin
				shades[1] = $signed($urandom);
				shades[2] = $signed($urandom);
				case ($urandom_range(0, 3))
					0: shades[3] = 32'sh8000_0000;
					1: shades[3] = 32'sh7fff_ffff;
					2: shades[3] = -1;
					default: shades[3] = $signed(32'($urandom_range(1, 9)));
				endcase
			end
			v = shades[$urandom_range(0, 3)];
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 4);
			for (int i = 0; i < len && sent < n; i++) begin
				f = (restart_odds > 0) && ($urandom_range(1, restart_odds) == 1);
				send_cell(v, f);
				sent++;
			end
		end
	endtask

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 15;
			default: return 30;
		endcase
	endfunction

	initial begin
		logic [LEN_W-1:0] phase_widths [11];
		logic [LEN_W-1:0] w;
		phase_widths = '{13'd3, 13'd64, 13'd4096, 13'd4097, 13'd13, 13'd1,
			13'd7, 13'd2, 13'd0, 13'd8191, 13'd17};
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		cell_value  = '0;
		first_cell  = 1'b0;
		out_ready   = 1'b0;
		gap_pct     = 0;
		stall_pct   = 0;
		stall_left  = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Short rows: extreme values, a dropped empty run, two runs closed by one row end,
		// and a restart in the middle of a row that drops the open run.
		gap_pct   = 20;
		stall_pct = 20;
		set_width(13'd5);
		send_cell(32'sh8000_0000, 1'b1);
		send_cell(32'sh8000_0000, 1'b0);
		send_cell(32'sh7fff_ffff, 1'b0);
		send_cell(32'sd0, 1'b0);
		send_cell(32'sd0, 1'b0);
		send_cell(32'sd7, 1'b0);
		send_cell(32'sd7, 1'b0);
		send_cell(-32'sd1, 1'b0);
		send_cell(-32'sd1, 1'b0);
		send_cell(32'sd5, 1'b0);
		send_cell(32'sd3, 1'b0);
		send_cell(32'sd3, 1'b0);
		send_cell(32'sd9, 1'b1);
		send_cell(32'sd9, 1'b0);
		send_cell(32'sd9, 1'b0);
		// The width drops below the current column, so the next cell ends the row.
		set_width(13'd2);
		send_cell(32'sd9, 1'b0);
		send_cell(32'sd4, 1'b0);
		send_cell(32'sd4, 1'b0);
		// A width of zero puts every cell in a row of its own.
		set_width(13'd0);
		send_cell(-32'sd2, 1'b0);
		send_cell(-32'sd2, 1'b0);
		send_cell(32'sd0, 1'b0);

		// Random phases over several widths; the last one runs without any idling.
		for (int k = 0; k < 11; k++) begin
			w = (k == 5) ? 13'($urandom_range(1, 40)) : phase_widths[k];
			gap_pct   = (k == 10) ? 0 : pick_pct();
			stall_pct = (k == 10) ? 0 : pick_pct();
			set_width(w);
			run_cells(132, 80);
		end

		settle();
		tracker.flag_missing();
		if (tracker.failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
design/grle_pkg.sv
design/grid_row_run_length_encoder_unit.sv
sim/grid_row_run_length_encoder_unit_tb.sv
